// ===== hdl/fcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcfs_pkg
// Shared types, codes and defaults for the FCFS multicore scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package fcfs_pkg;

    localparam int MAX_CORES_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_COUNT_DEF  = 64;

    localparam int ACTION_W  = 2;
    localparam int TASK_W    = 6;
    localparam int CORE_W    = 3;
    localparam int REASON_W  = 2;
    localparam int CFG_W     = 4;
    localparam int ACTIVE_W  = 7;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 8;

    localparam logic [CFG_W-1:0] CORES_RESET = 4'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_UNBLOCK = 2'd1,
        ACT_TICK    = 2'd2
    } t_action;

    typedef enum logic [REASON_W-1:0] {
        RSN_TIMER   = 2'd0,
        RSN_BLOCKED = 2'd1,
        RSN_EXITED  = 2'd2
    } t_reason;

    typedef enum logic [1:0] {
        MODE_RUN        = 2'd0,
        MODE_BLOCKED    = 2'd1,
        MODE_UNBLOCKING = 2'd2
    } t_mode;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic execute;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/fcfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcfs_ctrl
// Sequencer: table clear after reset, request capture, execute, result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module fcfs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output fcfs_pkg::t_cmd        o_cmd,
    input  wire fcfs_pkg::t_status i_status
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd.clear_wr = (r_state == S_CLEAR);
        o_cmd.capture  = (r_state == S_IDLE) && s_tvalid;
        o_cmd.execute  = (r_state == S_EXEC) && (!r_out_valid || m_tready);
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_status.clear_done) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_tvalid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (o_cmd.execute) r_state <= S_IDLE;
                end
                default: r_state <= S_CLEAR;
            endcase
            if (o_cmd.execute) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fcfs_dpath.sv =====
// ----------------------------------------------------------------------------
// fcfs_dpath
// Wait queue, per-core tables, blocked-core table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcfs_dpath #(
    parameter int MAX_CORES   = fcfs_pkg::MAX_CORES_DEF,
    parameter int QUEUE_DEPTH = fcfs_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_COUNT  = fcfs_pkg::TASK_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fcfs_pkg::t_cmd                i_cmd,
    output fcfs_pkg::t_status                  o_status,
    input  wire logic [fcfs_pkg::S_DATA_W-1:0] i_s_tdata,
    input  wire logic [fcfs_pkg::ACTION_W-1:0] i_s_tuser,
    input  wire logic                          i_cfg_we,
    input  wire logic [fcfs_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic [fcfs_pkg::M_DATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tuser
);

    localparam int CW   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int NW   = $clog2(QUEUE_DEPTH + 1);
    localparam int TW   = $clog2(TASK_COUNT);
    localparam int TSKW = fcfs_pkg::TASK_W;
    localparam int AW   = fcfs_pkg::ACTIVE_W;

    // request
    fcfs_pkg::t_action           r_action;
    logic [TSKW-1:0]             r_task;
    logic [fcfs_pkg::CORE_W-1:0] r_core;
    fcfs_pkg::t_reason           r_reason;

    logic [fcfs_pkg::CFG_W-1:0]  r_cores_in_use;

    // queue
    logic [TSKW-1:0] r_fifo_mem [QUEUE_DEPTH];
    logic [TSKW-1:0] r_fifo_rd;
    logic [QW-1:0]   r_head;
    logic [QW-1:0]   r_tail;
    logic [NW-1:0]   r_count;

    // blocked-core table
    logic [CW-1:0]   r_tbl_mem [TASK_COUNT];
    logic [CW-1:0]   r_tbl_rd;
    logic [TW-1:0]   r_clr_addr;

    // per-core tables
    fcfs_pkg::t_mode r_mode     [MAX_CORES];
    logic            r_cur_idle [MAX_CORES];
    logic [TSKW-1:0] r_cur_task [MAX_CORES];
    logic [TSKW-1:0] r_saved    [MAX_CORES];

    logic [TSKW-1:0] r_out_task;
    logic            r_out_idle;
    logic            r_out_drop;
    logic            r_out_sched;

    logic [AW-1:0]   active;
    logic [CW-1:0]   ci;
    logic            core_ok;
    logic            cur_idle;
    logic [TSKW-1:0] cur_task;
    fcfs_pkg::t_mode cur_mode;

    logic            fifo_we;
    logic            fifo_pop;
    logic            mode_we;
    logic [CW-1:0]   mode_idx;
    fcfs_pkg::t_mode mode_val;
    logic            cur_we;
    logic            saved_we;
    logic            tbl_exec_we;
    logic            tbl_we;
    logic [TW-1:0]   tbl_waddr;
    logic [CW-1:0]   tbl_wdata;

    logic            res_idle;
    logic [TSKW-1:0] res_task;
    logic            res_drop;
    logic            res_sched;

    always_comb begin
        if (r_cores_in_use == '0) begin
            active = AW'(1);
        end else if (32'(r_cores_in_use) > 32'(MAX_CORES)) begin
            active = AW'(MAX_CORES);
        end else begin
            active = AW'(r_cores_in_use);
        end
    end

    assign ci       = CW'(r_core);
    assign core_ok  = AW'(r_core) < active;
    assign cur_idle = r_cur_idle[ci];
    assign cur_task = r_cur_task[ci];
    assign cur_mode = r_mode[ci];

    always_comb begin
        fifo_we     = 1'b0;
        fifo_pop    = 1'b0;
        mode_we     = 1'b0;
        mode_idx    = ci;
        mode_val    = fcfs_pkg::MODE_RUN;
        cur_we      = 1'b0;
        saved_we    = 1'b0;
        tbl_exec_we = 1'b0;
        res_idle    = 1'b0;
        res_task    = '0;
        res_drop    = 1'b0;
        res_sched   = 1'b0;
        case (r_action)
            fcfs_pkg::ACT_LOAD: begin
                if (r_count == NW'(QUEUE_DEPTH)) res_drop = 1'b1;
                else                             fifo_we  = 1'b1;
            end
            fcfs_pkg::ACT_UNBLOCK: begin
                if (32'(r_task) >= 32'(TASK_COUNT) || AW'(r_tbl_rd) >= active) begin
                    res_drop = 1'b1;
                end else begin
                    mode_we  = 1'b1;
                    mode_idx = r_tbl_rd;
                    mode_val = fcfs_pkg::MODE_UNBLOCKING;
                end
            end
            fcfs_pkg::ACT_TICK: begin
                res_sched = 1'b1;
                if (!core_ok) begin
                    res_drop = 1'b1;
                    res_idle = 1'b1;
                end else begin
                    cur_we   = 1'b1;
                    res_idle = 1'b1;
                    if (r_reason == fcfs_pkg::RSN_EXITED
                        || (cur_idle && cur_mode == fcfs_pkg::MODE_RUN)) begin
                        if (r_count != '0) begin
                            fifo_pop = 1'b1;
                            res_idle = 1'b0;
                            res_task = r_fifo_rd;
                        end
                    end else if (r_reason == fcfs_pkg::RSN_TIMER
                                 && cur_mode == fcfs_pkg::MODE_RUN) begin
                        res_idle = 1'b0;
                        res_task = cur_task;
                    end else if (r_reason == fcfs_pkg::RSN_TIMER
                                 && cur_mode == fcfs_pkg::MODE_UNBLOCKING) begin
                        mode_we  = 1'b1;
                        mode_val = fcfs_pkg::MODE_RUN;
                        res_idle = 1'b0;
                        res_task = r_saved[ci];
                    end else if (r_reason == fcfs_pkg::RSN_BLOCKED) begin
                        mode_we  = 1'b1;
                        mode_val = fcfs_pkg::MODE_BLOCKED;
                        if (!cur_idle) begin
                            saved_we    = 1'b1;
                            tbl_exec_we = 32'(cur_task) < 32'(TASK_COUNT);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign tbl_we    = i_cmd.clear_wr || (i_cmd.execute && tbl_exec_we);
    assign tbl_waddr = i_cmd.clear_wr ? r_clr_addr : TW'(cur_task);
    assign tbl_wdata = i_cmd.clear_wr ? '0 : ci;

    assign o_status.clear_done = (r_clr_addr == TW'(TASK_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && fifo_we) r_fifo_mem[r_tail] <= r_task;
        if (i_cmd.capture)            r_fifo_rd <= r_fifo_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we)        r_tbl_mem[tbl_waddr] <= tbl_wdata;
        if (i_cmd.capture) r_tbl_rd <= r_tbl_mem[TW'(i_s_tdata[TSKW-1:0])];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= fcfs_pkg::t_action'(i_s_tuser);
            r_task   <= i_s_tdata[TSKW-1:0];
            r_core   <= i_s_tdata[TSKW+fcfs_pkg::CORE_W-1:TSKW];
            r_reason <= fcfs_pkg::t_reason'(
                i_s_tdata[TSKW+fcfs_pkg::CORE_W+fcfs_pkg::REASON_W-1:TSKW+fcfs_pkg::CORE_W]);
        end
        if (i_cmd.execute) begin
            r_out_task  <= res_task;
            r_out_idle  <= res_idle;
            r_out_drop  <= res_drop;
            r_out_sched <= res_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cores_in_use <= fcfs_pkg::CORES_RESET;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_clr_addr     <= '0;
            for (int i = 0; i < MAX_CORES; i++) begin
                r_mode[i]     <= fcfs_pkg::MODE_RUN;
                r_cur_idle[i] <= 1'b1;
                r_cur_task[i] <= '0;
                r_saved[i]    <= '0;
            end
        end else begin
            if (i_cfg_we) r_cores_in_use <= i_cfg_wdata;
            if (i_cmd.clear_wr && !o_status.clear_done) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.execute) begin
                if (fifo_we) begin
                    r_tail  <= (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    r_count <= r_count + 1'b1;
                end
                if (fifo_pop) begin
                    r_head  <= (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    r_count <= r_count - 1'b1;
                end
                if (mode_we) r_mode[mode_idx] <= mode_val;
                if (saved_we) r_saved[ci] <= cur_task;
                if (cur_we) begin
                    r_cur_idle[ci] <= res_idle;
                    r_cur_task[ci] <= res_task;
                end
            end
        end
    end

    assign o_m_tdata = {r_out_drop, r_out_idle, r_out_task};
    assign o_m_tuser = r_out_sched;

endmodule

`default_nettype wire

// ===== hdl/fcfs_multicore_scheduler.sv =====
// ----------------------------------------------------------------------------
// fcfs_multicore_scheduler
// Non-preemptive first-come-first-served scheduler for several cores.
//
//   port group | dir | payload
//   s_*        | in  | request: load, unblock or core tick
//   m_*        | out | one result per request
//   i_cfg_*    | in  | cores_in_use write
//
// Each request is captured, with the table and queue reads, and then
// executed; the registered memory reads set this order.
// After reset the blocked-core table is cleared, one entry at a time,
// with s_tready low. A new request is taken while a result waits on m_*;
// a request whose result cannot be loaded holds in execute.
// ----------------------------------------------------------------------------
`default_nettype none

module fcfs_multicore_scheduler #(
    parameter int MAX_CORES   = fcfs_pkg::MAX_CORES_DEF,
    parameter int QUEUE_DEPTH = fcfs_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_COUNT  = fcfs_pkg::TASK_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // task_id[5:0], core[8:6], reason[10:9], zero pad
    input  wire logic [fcfs_pkg::S_DATA_W-1:0] s_tdata,
    // action[1:0]
    input  wire logic [fcfs_pkg::ACTION_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // run_task[5:0], run_idle[6], dropped[7]
    output logic [fcfs_pkg::M_DATA_W-1:0]      m_tdata,
    // is_schedule[0]
    output logic                               m_tuser,
    input  wire logic                          i_cfg_we,
    input  wire logic [fcfs_pkg::CFG_W-1:0]    i_cfg_wdata
);

    fcfs_pkg::t_cmd    cmd;
    fcfs_pkg::t_status status;

    fcfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .o_cmd    (cmd),
        .i_status (status)
    );

    fcfs_dpath #(
        .MAX_CORES   (MAX_CORES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TASK_COUNT  (TASK_COUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
